// ===== rtl/tssa_pkg.sv =====
// Shared constants and types for the template score smoother with argmax.
`default_nettype none

package tssa_pkg;

   localparam int MAX_OBJECTS = 16;

   localparam int FEAT_W   = 16;
   localparam int DIFF_W   = FEAT_W + 1;
   localparam int SQSUM_W  = 34;
   localparam int WEIGHT_W = 16;
   localparam int WPROD_W  = SQSUM_W + WEIGHT_W;
   localparam int INST_W   = 36;
   localparam int BLEND_W  = 17;
   localparam int BPROD_W  = INST_W + BLEND_W + 1;
   localparam int FRAC_W   = 16;
   localparam int SCORE_W  = 48;
   localparam int MARGIN_W = 47;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] REG_OBJ_COUNT      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SIG_INTENSITY  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SIG_SIZE       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIG_DECEL      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_FEATURE_WEIGHT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_BLEND          = 3'd5;

   localparam logic [BLEND_W-1:0]  BLEND_ONE  = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;
   localparam logic [COUNT_W-1:0]  COUNT_RST  = 5'd1;
   localparam logic signed [SCORE_W-1:0] MOST_NEG = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef logic signed [FEAT_W-1:0]  feat_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [SCORE_W-1:0] score_type;

endpackage

`default_nettype wire

// ===== rtl/template_score_smoother_argmax.sv =====
// Top level: weighted template distance, exponential smoothing and argmax per frame.
//
//   Channel   Direction   Beat contents (lowest bits first)
//   req_      in          feat_intensity, feat_size, feat_decel
//   rsp_      out         selected_index, margin, best_score
//   csr_      in          register index and write data, no handshake
//
// Each item is accepted in the idle state, then the sequencer walks the squares,
// the weight multiply, the blend multiply, the score write-back and the argmax update.
// The per-object scores live in one memory read at accept and written back once.
// Reset is synchronous and clears control state; the score memory is not cleared.
// A result waiting in the output register stalls the last object of the next frame.
`default_nettype none

module template_score_smoother_argmax (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // feat_intensity [15:0], feat_size [31:16], feat_decel [47:32]
   input  wire  [3*tssa_pkg::FEAT_W-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // selected_index [3:0], margin [50:4], best_score [98:51], zero [103:99]
   output logic [103:0]                         rsp_tdata,
   input  wire                                  csr_we,
   input  wire  [tssa_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire  [tssa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int POS_W = (tssa_pkg::MAX_OBJECTS > 1) ? $clog2(tssa_pkg::MAX_OBJECTS) : 1;
   localparam int NUM_W = $clog2(tssa_pkg::MAX_OBJECTS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_WT   = 3'd2;
   localparam logic [2:0] ST_BL   = 3'd3;
   localparam logic [2:0] ST_UPD  = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;

   logic [tssa_pkg::COUNT_W-1:0]  num_ff, num_in;
   tssa_pkg::feat_type            sig0_ff, sig0_in, sig1_ff, sig1_in, sig2_ff, sig2_in;
   logic [tssa_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [tssa_pkg::BLEND_W-1:0]  blend_ff, blend_in;

   logic [2:0]                    state_ff, state_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          seeded_ff, seeded_in;
   logic [POS_W-1:0]              best_idx_ff, best_idx_in;
   tssa_pkg::score_type           best_ff, best_in;
   tssa_pkg::score_type           second_ff, second_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [103:0]                  rsp_data_ff, rsp_data_in;

   tssa_pkg::diff_type                    d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in;
   logic [tssa_pkg::SQSUM_W-1:0]          sqsum_ff, sqsum_in;
   logic signed [tssa_pkg::INST_W-1:0]    inst_ff, inst_in;
   logic signed [tssa_pkg::BPROD_W-1:0]   bprod_ff, bprod_in;
   tssa_pkg::score_type                   snew_ff, snew_in;
   tssa_pkg::score_type                   rd_data_ff;
   tssa_pkg::score_type                   score_mem [tssa_pkg::MAX_OBJECTS];

   logic                                  accept;
   logic                                  last;
   logic                                  emit_go;
   logic [NUM_W-1:0]                      n_eff;
   logic signed [2*tssa_pkg::DIFF_W-1:0]  sq0, sq1, sq2;
   logic [tssa_pkg::WPROD_W-1:0]          wprod;
   logic signed [tssa_pkg::INST_W-1:0]    s_trunc, sdiff;
   logic signed [tssa_pkg::BPROD_W-tssa_pkg::FRAC_W-1:0] adj;
   logic [tssa_pkg::MARGIN_W-1:0]         margin_full;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (num_ff == '0) begin
         n_eff = NUM_W'(1);
      end else if (32'(num_ff) > tssa_pkg::MAX_OBJECTS) begin
         n_eff = NUM_W'(tssa_pkg::MAX_OBJECTS);
      end else begin
         n_eff = NUM_W'(num_ff);
      end
   end

   assign last    = (32'(pos_ff) + 32'd1) >= 32'(n_eff);
   assign emit_go = !last || !rsp_valid_ff || rsp_tready;

   assign sq0   = d0_ff * d0_ff;
   assign sq1   = d1_ff * d1_ff;
   assign sq2   = d2_ff * d2_ff;
   assign wprod = tssa_pkg::WPROD_W'(sqsum_ff) * tssa_pkg::WPROD_W'(weight_ff);

   assign s_trunc = rd_data_ff[tssa_pkg::INST_W-1:0];
   assign sdiff   = inst_ff - s_trunc;
   assign adj     = bprod_ff[tssa_pkg::BPROD_W-1:tssa_pkg::FRAC_W];

   assign margin_full = tssa_pkg::MARGIN_W'(best_in - second_in);

   always_comb begin
      num_in    = num_ff;
      sig0_in   = sig0_ff;
      sig1_in   = sig1_ff;
      sig2_in   = sig2_ff;
      weight_in = weight_ff;
      blend_in  = blend_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tssa_pkg::REG_OBJ_COUNT:      num_in    = csr_wdata[tssa_pkg::COUNT_W-1:0];
            tssa_pkg::REG_SIG_INTENSITY:  sig0_in   = csr_wdata[tssa_pkg::FEAT_W-1:0];
            tssa_pkg::REG_SIG_SIZE:       sig1_in   = csr_wdata[tssa_pkg::FEAT_W-1:0];
            tssa_pkg::REG_SIG_DECEL:      sig2_in   = csr_wdata[tssa_pkg::FEAT_W-1:0];
            tssa_pkg::REG_FEATURE_WEIGHT: weight_in = csr_wdata[tssa_pkg::WEIGHT_W-1:0];
            tssa_pkg::REG_BLEND: begin
               blend_in = (csr_wdata > tssa_pkg::BLEND_ONE) ? tssa_pkg::BLEND_ONE : csr_wdata;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      seeded_in    = seeded_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      d0_in        = d0_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      sqsum_in     = sqsum_ff;
      inst_in      = inst_ff;
      bprod_in     = bprod_ff;
      snew_in      = snew_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               d0_in    = tssa_pkg::DIFF_W'($signed(req_tdata[15:0]))
                        - tssa_pkg::DIFF_W'(sig0_ff);
               d1_in    = tssa_pkg::DIFF_W'($signed(req_tdata[31:16]))
                        - tssa_pkg::DIFF_W'(sig1_ff);
               d2_in    = tssa_pkg::DIFF_W'($signed(req_tdata[47:32]))
                        - tssa_pkg::DIFF_W'(sig2_ff);
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sqsum_in = tssa_pkg::SQSUM_W'($unsigned(sq0)) + tssa_pkg::SQSUM_W'($unsigned(sq1))
                     + tssa_pkg::SQSUM_W'($unsigned(sq2));
            state_in = ST_WT;
         end
         ST_WT: begin
            inst_in  = -$signed({2'b00, wprod[tssa_pkg::WPROD_W-1:tssa_pkg::FRAC_W]});
            state_in = ST_BL;
         end
         ST_BL: begin
            bprod_in = tssa_pkg::BPROD_W'(sdiff) * tssa_pkg::BPROD_W'($signed({1'b0, blend_ff}));
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (seeded_ff) begin
               snew_in = rd_data_ff + tssa_pkg::SCORE_W'(adj);
            end else begin
               snew_in = tssa_pkg::SCORE_W'(inst_ff);
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (emit_go) begin
               if (pos_ff == '0) begin
                  best_idx_in = '0;
                  best_in     = snew_ff;
                  second_in   = tssa_pkg::MOST_NEG;
               end else if (snew_ff > best_ff) begin
                  second_in   = best_ff;
                  best_in     = snew_ff;
                  best_idx_in = pos_ff;
               end else if (snew_ff > second_ff) begin
                  second_in   = snew_ff;
               end
               if (last) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {5'b0, best_in,
                                  (n_eff >= NUM_W'(2)) ? margin_full
                                                       : {tssa_pkg::MARGIN_W{1'b0}},
                                  tssa_pkg::INDEX_W'(best_idx_in)};
                  pos_in       = '0;
                  seeded_in    = 1'b1;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= tssa_pkg::COUNT_RST;
         sig0_ff      <= '0;
         sig1_ff      <= '0;
         sig2_ff      <= '0;
         weight_ff    <= tssa_pkg::WEIGHT_RST;
         blend_ff     <= tssa_pkg::BLEND_ONE;
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         seeded_ff    <= 1'b0;
         best_idx_ff  <= '0;
         best_ff      <= '0;
         second_ff    <= tssa_pkg::MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         sig0_ff      <= sig0_in;
         sig1_ff      <= sig1_in;
         sig2_ff      <= sig2_in;
         weight_ff    <= weight_in;
         blend_ff     <= blend_in;
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         seeded_ff    <= seeded_in;
         best_idx_ff  <= best_idx_in;
         best_ff      <= best_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      sqsum_ff    <= sqsum_in;
      inst_ff     <= inst_in;
      bprod_ff    <= bprod_in;
      snew_ff     <= snew_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= score_mem[pos_ff];
      end
      if (state_ff == ST_UPD) begin
         score_mem[pos_ff] <= snew_in;
      end
   end

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < tssa_pkg::MAX_OBJECTS)
      else $error("Object position beyond the score memory.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SQ)
      else $error("Accepted beat did not start the score sequence.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CMP && $past(last))
      else $error("Result raised outside the end of a frame.");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && emit_go && last) |=> pos_ff == '0 && seeded_ff)
      else $error("Frame end did not rewind the position and mark seeding.");
`endif

endmodule

`default_nettype wire
